FILE: hw/rtl/lag_pkg.sv
// Shared types and command codes for the life automaton grid.
package lag_pkg;

    // Command codes carried in the kind field
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    // Rule thresholds: birth on three neighbors, survival on two or three
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        cell_value;
        logic [15:0] generations;
    } t_in_item;

    typedef struct packed {
        logic       alive;
        logic [1:0] done_kind;
    } t_out_item;

    // Control from the sequencer to every row cell
    typedef struct packed {
        logic step;
        logic wr;
        logic wr_val;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/lag_if.sv
// Valid/ready channel interfaces for command and result transactions.
interface lag_in_if;
    import lag_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lag_out_if;
    import lag_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/lag_row_cell.sv
// One row of the torus: holds its cells and applies the B3/S23 rule using its neighbor rows.
module lag_row_cell #(
    parameter int GRID_SIDE = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lag_pkg::t_cell_ctrl          i_ctrl,
    input  logic                         i_row_sel,
    input  logic [$clog2(GRID_SIDE)-1:0] i_col,
    input  logic [GRID_SIDE-1:0]         i_up_row,
    input  logic [GRID_SIDE-1:0]         i_dn_row,
    output logic [GRID_SIDE-1:0]         o_row
);
    import lag_pkg::*;

    logic [GRID_SIDE-1:0] r_row;
    logic [GRID_SIDE-1:0] n_row;

    // Count the eight neighbors of each cell, wrapping at the row ends
    for (genvar b = 0; b < GRID_SIDE; b++) begin : g_bit
        localparam int BW = (b + GRID_SIDE - 1) % GRID_SIDE;
        localparam int BE = (b + 1) % GRID_SIDE;
        logic [3:0] w_cnt;
        assign w_cnt = 4'(i_up_row[BW]) + 4'(i_up_row[b]) + 4'(i_up_row[BE])
                     + 4'(r_row[BW])    + 4'(r_row[BE])
                     + 4'(i_dn_row[BW]) + 4'(i_dn_row[b]) + 4'(i_dn_row[BE]);
        assign n_row[b] = (w_cnt == BIRTH_COUNT) ||
                          ((w_cnt == SURVIVE_COUNT) && r_row[b]);
    end

    // Advance one generation, or update the addressed cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_ctrl.step) begin
            r_row <= n_row;
        end else if (i_ctrl.wr && i_row_sel) begin
            r_row[i_col] <= i_ctrl.wr_val;
        end
    end

    assign o_row = r_row;

endmodule

FILE: hw/rtl/life_automaton_grid.sv
// Top level of the life automaton grid: command sequencer, result register and row cell chain.
// A GRID_SIDE by GRID_SIDE toroidal grid of one-bit cells (GRID_SIDE a power of two, 4 to
// 1024), all dead after reset, held in a chain of row cells that each see the rows above
// and below. A write or read transaction has its result registered at the accepting edge;
// coordinates wrap modulo GRID_SIDE, and cells past column or row 63 are reachable only
// through evolution. A run of N generations holds off the input until the generation counter
// runs out (a run of zero generations is answered like a write or read): every row cell
// applies the B3/S23 rule to its whole row at each step, so the run length is set by the
// generation counter alone. No new command is taken during a run.
// A command is accepted while a finished result still waits, provided it is taken in the
// same cycle; unknown kind codes leave the grid alone and echo their kind with alive low.
module life_automaton_grid #(
    parameter int GRID_SIDE = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lag_in_if.sink    i_in,
    lag_out_if.source o_out
);
    import lag_pkg::*;

    localparam int IDX_W = $clog2(GRID_SIDE);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state     r_state;
    logic       r_out_valid;
    t_out_item  r_out_data;
    logic [15:0] r_gens_left;

    logic                  w_accept;
    logic                  w_run_start;
    t_cell_ctrl            w_ctrl;
    logic [IDX_W-1:0]      w_x;
    logic [IDX_W-1:0]      w_y;
    logic [IDX_W+5:0]      w_x_ext;
    logic [IDX_W+5:0]      w_y_ext;
    logic [GRID_SIDE-1:0]  w_rows [GRID_SIDE];
    logic                  w_read_bit;

    // Wrap coordinates onto the torus
    assign w_x_ext = {{IDX_W{1'b0}}, i_in.data.cell_x};
    assign w_y_ext = {{IDX_W{1'b0}}, i_in.data.cell_y};
    assign w_x     = w_x_ext[IDX_W-1:0];
    assign w_y     = w_y_ext[IDX_W-1:0];

    // Take a command when idle and the result register is free or draining
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_run_start = w_accept && (i_in.data.kind == KIND_RUN) &&
                         (i_in.data.generations != 16'd0);

    assign w_ctrl.step   = (r_state == S_RUN);
    assign w_ctrl.wr     = w_accept && (i_in.data.kind == KIND_WRITE);
    assign w_ctrl.wr_val = i_in.data.cell_value;

    // Chain of row cells, closed into a ring
    for (genvar g = 0; g < GRID_SIDE; g++) begin : g_row
        localparam int UP = (g + GRID_SIDE - 1) % GRID_SIDE;
        localparam int DN = (g + 1) % GRID_SIDE;
        lag_row_cell #(
            .GRID_SIDE(GRID_SIDE)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_row_sel (w_y == IDX_W'(g)),
            .i_col     (w_x),
            .i_up_row  (w_rows[UP]),
            .i_dn_row  (w_rows[DN]),
            .o_row     (w_rows[g])
        );
    end

    assign w_read_bit = w_rows[w_y][w_x];

    // Sequence commands and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_run_start) begin
                        r_state     <= S_RUN;
                        r_gens_left <= i_in.data.generations;
                        r_out_valid <= 1'b0;
                    end else if (w_accept) begin
                        r_out_valid          <= 1'b1;
                        r_out_data.alive     <= (i_in.data.kind == KIND_READ) && w_read_bit;
                        r_out_data.done_kind <= i_in.data.kind;
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_RUN: begin
                    r_gens_left <= r_gens_left - 16'd1;
                    if (r_gens_left == 16'd1) begin
                        r_state              <= S_IDLE;
                        r_out_valid          <= 1'b1;
                        r_out_data.alive     <= 1'b0;
                        r_out_data.done_kind <= KIND_RUN;
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // A grid step never coincides with a cell write
    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.step && w_ctrl.wr))
        else $error("cell write during generation step");

    // No command is taken while generations are running
    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !i_in.ready)
        else $error("command accepted during run");

    // The last generation posts the done result
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && (r_gens_left == 16'd1)) |=>
            (r_out_valid && (r_out_data.done_kind == KIND_RUN) && (r_state == S_IDLE)))
        else $error("run finished without result");

    // A run never starts with a zero count
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_gens_left != 16'd0))
        else $error("generation counter underflow");

endmodule
